/* design/ticks_to_civil_date_unit_macros.svh */
// Assertion macros shared by the civil date converter.
`ifndef TICKS_TO_CIVIL_DATE_UNIT_MACROS_SVH
`define TICKS_TO_CIVIL_DATE_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define TTCD_CHECK(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define TTCD_CHECK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/ttcd_pkg.sv */
// Types, constants and calendar tables for the civil date converter.
package ttcd_pkg;

    localparam int TICK_W            = 62;
    localparam int IN_TDATA_W        = 64;
    localparam int DAY_SHIFT         = 14;
    localparam int SCALED_W          = TICK_W - DAY_SHIFT;
    localparam int DAYNUM_W          = 22;
    localparam int DIV_STEPS         = DAYNUM_W;
    localparam int CAL_STEPS         = 14;
    localparam int YEAR_W            = 14;
    localparam int MONTH_W           = 4;
    localparam int DAY_W             = 5;
    localparam int DOY_W             = 9;
    localparam int MONTH_GUESS_SHIFT = 5;
    localparam int OUT_TDATA_W       = 24;

    typedef logic [TICK_W-1:0]    tick_t;
    typedef logic [SCALED_W-1:0]  scaled_t;
    typedef logic [DAYNUM_W-1:0]  daynum_t;
    typedef logic [YEAR_W-1:0]    year_t;
    typedef logic [MONTH_W-1:0]   month_t;
    typedef logic [DAY_W-1:0]     dom_t;
    typedef logic [DOY_W-1:0]     doy_t;
    typedef logic [CAL_STEPS-1:0] cal_mask_t;

    // Last tick of 31 December 9999.
    localparam tick_t MAX_TICK = 62'd3155378975999999999;

    // Ticks per day is 2^14 * 52734375; the power of two is dropped by a shift.
    localparam scaled_t DAY_DIV = 48'd52734375;

    localparam month_t MONTHS = 4'd12;

    // Calendar split as restoring steps: 400-year periods (five steps),
    // 100-year periods (two steps, so a count of four saturates at three),
    // 4-year periods (five steps) and 1-year periods (two steps, saturating).
    localparam daynum_t CAL_DIV [CAL_STEPS] = '{
        22'd2337552, 22'd1168776, 22'd584388, 22'd292194, 22'd146097,
        22'd73048,   22'd36524,
        22'd23376,   22'd11688,   22'd5844,   22'd2922,   22'd1461,
        22'd730,     22'd365
    };
    localparam year_t CAL_YEARS [CAL_STEPS] = '{
        14'd6400, 14'd3200, 14'd1600, 14'd800, 14'd400,
        14'd200,  14'd100,
        14'd64,   14'd32,   14'd16,   14'd8,   14'd4,
        14'd2,    14'd1
    };

    // Step positions used by the leap-year test.
    localparam int STEP_Q100_HI = 5;
    localparam int STEP_Q100_LO = 6;
    localparam int STEP_Q4_16   = 7;
    localparam int STEP_Q4_8    = 8;
    localparam int STEP_Q4_4    = 9;
    localparam int STEP_Q4_2    = 10;
    localparam int STEP_Q4_1    = 11;
    localparam int STEP_Q1_HI   = 12;
    localparam int STEP_Q1_LO   = 13;

    localparam doy_t CUM_COMMON [13] = '{
        9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151, 9'd181,
        9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd365
    };
    localparam doy_t CUM_LEAP [13] = '{
        9'd0, 9'd31, 9'd60, 9'd91, 9'd121, 9'd152, 9'd182,
        9'd213, 9'd244, 9'd274, 9'd305, 9'd335, 9'd366
    };

    typedef struct packed {
        logic    err;
        scaled_t scaled;
    } scaled_item_t;

    typedef struct packed {
        logic    err;
        daynum_t day_num;
    } day_item_t;

    typedef struct packed {
        logic   err;
        logic   leap;
        dom_t   day;
        month_t month;
        year_t  year;
    } date_t;

    function automatic doy_t cum_days(input logic leap, input month_t idx);
        doy_t val;
        val = '0;
        if (idx <= MONTHS)
        begin
            val = leap ? CUM_LEAP[idx] : CUM_COMMON[idx];
        end
        return val;
    endfunction

endpackage

/* design/ttcd_divider.sv */
// Pipelined restoring divider that turns scaled ticks into a day number.
module ttcd_divider (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    adv,
    input  logic                    in_valid,
    input  ttcd_pkg::scaled_item_t  in_item,
    output logic                    out_valid,
    output ttcd_pkg::day_item_t     out_item
);
    import ttcd_pkg::*;

    logic    valid_reg [DIV_STEPS];
    scaled_t rem_reg   [DIV_STEPS];
    daynum_t quot_reg  [DIV_STEPS];
    logic    err_reg   [DIV_STEPS];

    // Each stage settles one quotient bit, most significant first.
    for (genvar s = 0; s < DIV_STEPS; s++)
    begin : g_step
        localparam scaled_t STEP_DIV = DAY_DIV << (DIV_STEPS - 1 - s);

        logic              valid_prev;
        scaled_t           rem_prev;
        daynum_t           quot_prev;
        logic              err_prev;
        logic [SCALED_W:0] diff;
        logic              taken;
        scaled_t           rem_next;
        daynum_t           quot_next;

        if (s == 0)
        begin : g_first
            assign valid_prev = in_valid;
            assign rem_prev   = in_item.scaled;
            assign quot_prev  = '0;
            assign err_prev   = in_item.err;
        end
        else
        begin : g_rest
            assign valid_prev = valid_reg[s-1];
            assign rem_prev   = rem_reg[s-1];
            assign quot_prev  = quot_reg[s-1];
            assign err_prev   = err_reg[s-1];
        end

        assign diff      = {1'b0, rem_prev} - {1'b0, STEP_DIV};
        assign taken     = !diff[SCALED_W];
        assign rem_next  = taken ? diff[SCALED_W-1:0] : rem_prev;
        assign quot_next = {quot_prev[DAYNUM_W-2:0], taken};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[s] <= 1'b0;
            end
            else if (adv)
            begin
                valid_reg[s] <= valid_prev;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_reg[s]  <= rem_next;
                quot_reg[s] <= quot_next;
                err_reg[s]  <= err_prev;
            end
        end
    end

    assign out_valid        = valid_reg[DIV_STEPS-1];
    assign out_item.err     = err_reg[DIV_STEPS-1];
    assign out_item.day_num = quot_reg[DIV_STEPS-1];

endmodule

/* design/ttcd_calendar.sv */
// Pipelined split of a day number into year, month, day and leap flag.
module ttcd_calendar (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 adv,
    input  logic                 in_valid,
    input  ttcd_pkg::day_item_t  in_item,
    output logic                 out_valid,
    output ttcd_pkg::date_t      out_date
);
    import ttcd_pkg::*;

    logic      valid_reg [CAL_STEPS];
    daynum_t   rem_reg   [CAL_STEPS];
    year_t     year_reg  [CAL_STEPS];
    cal_mask_t mask_reg  [CAL_STEPS];
    logic      err_reg   [CAL_STEPS];

    // One compare and subtract per stage; the year weight of each taken step
    // is added as it goes, and the taken steps are kept for the leap test.
    for (genvar s = 0; s < CAL_STEPS; s++)
    begin : g_step
        logic              valid_prev;
        daynum_t           rem_prev;
        year_t             year_prev;
        cal_mask_t         mask_prev;
        logic              err_prev;
        logic [DAYNUM_W:0] diff;
        logic              taken;
        daynum_t           rem_next;
        year_t             year_next;
        cal_mask_t         mask_next;

        if (s == 0)
        begin : g_first
            assign valid_prev = in_valid;
            assign rem_prev   = in_item.day_num;
            assign year_prev  = '0;
            assign mask_prev  = '0;
            assign err_prev   = in_item.err;
        end
        else
        begin : g_rest
            assign valid_prev = valid_reg[s-1];
            assign rem_prev   = rem_reg[s-1];
            assign year_prev  = year_reg[s-1];
            assign mask_prev  = mask_reg[s-1];
            assign err_prev   = err_reg[s-1];
        end

        assign diff      = {1'b0, rem_prev} - {1'b0, CAL_DIV[s]};
        assign taken     = !diff[DAYNUM_W];
        assign rem_next  = taken ? diff[DAYNUM_W-1:0] : rem_prev;
        assign year_next = year_prev + (taken ? CAL_YEARS[s] : year_t'(0));
        assign mask_next = mask_prev | (cal_mask_t'(taken) << s);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[s] <= 1'b0;
            end
            else if (adv)
            begin
                valid_reg[s] <= valid_prev;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_reg[s]  <= rem_next;
                year_reg[s] <= year_next;
                mask_reg[s] <= mask_next;
                err_reg[s]  <= err_prev;
            end
        end
    end

    // Month stage.
    cal_mask_t last_mask;
    doy_t      doy;
    month_t    guess_base;
    month_t    mo_guess;
    logic      q4_is_24;
    logic      leap_next;
    month_t    mo_next;
    year_t     year_next;

    logic      mo_valid_reg;
    month_t    mo_reg;
    doy_t      doy_reg;
    logic      leap_reg;
    year_t     mo_year_reg;
    logic      mo_err_reg;

    assign last_mask  = mask_reg[CAL_STEPS-1];
    assign doy        = rem_reg[CAL_STEPS-1][DOY_W-1:0];
    assign guess_base = doy[DOY_W-1:MONTH_GUESS_SHIFT];
    assign mo_guess   = (guess_base >= MONTHS - month_t'(1)) ? MONTHS
                                                             : guess_base + month_t'(1);
    assign q4_is_24   = last_mask[STEP_Q4_16] && last_mask[STEP_Q4_8] &&
                        !last_mask[STEP_Q4_4] && !last_mask[STEP_Q4_2] &&
                        !last_mask[STEP_Q4_1];
    assign leap_next  = last_mask[STEP_Q1_HI] && last_mask[STEP_Q1_LO] &&
                        (!q4_is_24 ||
                         (last_mask[STEP_Q100_HI] && last_mask[STEP_Q100_LO]));
    assign mo_next    = (mo_guess < MONTHS && doy >= cum_days(leap_next, mo_guess))
                        ? mo_guess + month_t'(1) : mo_guess;
    assign year_next  = year_reg[CAL_STEPS-1] + year_t'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mo_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            mo_valid_reg <= valid_reg[CAL_STEPS-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mo_reg      <= mo_next;
            doy_reg     <= doy;
            leap_reg    <= leap_next;
            mo_year_reg <= year_next;
            mo_err_reg  <= err_reg[CAL_STEPS-1];
        end
    end

    // Day stage, which also clears the date of an out-of-range transfer.
    doy_t  day_wide;
    date_t date_next;
    logic  out_valid_reg;
    date_t out_date_reg;

    assign day_wide = doy_reg - cum_days(leap_reg, mo_reg - month_t'(1)) + doy_t'(1);

    always_comb
    begin
        date_next.err   = mo_err_reg;
        date_next.leap  = mo_err_reg ? 1'b0 : leap_reg;
        date_next.day   = mo_err_reg ? dom_t'(0) : day_wide[DAY_W-1:0];
        date_next.month = mo_err_reg ? month_t'(0) : mo_reg;
        date_next.year  = mo_err_reg ? year_t'(0) : mo_year_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= mo_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_date_reg <= date_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_date  = out_date_reg;

endmodule

/* design/ticks_to_civil_date_unit.sv */
// Throughput: one transfer per cycle while the skid register is empty; the depth comes
// from the 22-stage day divider, the 14 calendar split stages, the month stage, the day
// stage and the input stage. A two-entry output (result register plus skid register)
// lets input continue while a result waits. Reset clears only the valid bits and the
// skid flag.
`include "ticks_to_civil_date_unit_macros.svh"

module ticks_to_civil_date_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [ttcd_pkg::IN_TDATA_W-1:0]   s_tdata,   // [61:0] tick_count, [63:62] zero
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [ttcd_pkg::OUT_TDATA_W-1:0]  m_tdata,   // [13:0] year_value,
                                                         // [17:14] month_value,
                                                         // [22:18] day_value,
                                                         // [23] leap_flag
    output logic                              m_tuser    // [0] range_error
);
    import ttcd_pkg::*;

    // The whole pipeline moves as one whenever the skid register is free.
    // The skid register is only filled when the result register holds a
    // transfer that the sink has not taken, so no result is lost or doubled.
    logic adv;
    logic skid_valid_reg;

    assign adv      = !skid_valid_reg;
    assign s_tready = !skid_valid_reg;

    // Input stage: range check against the last tick of 9999-12-31, and the
    // power-of-two part of the ticks-per-day division done as a shift.
    tick_t        tick_in;
    logic         in_valid_reg;
    scaled_item_t in_item_reg;
    scaled_item_t in_item_next;

    assign tick_in             = s_tdata[TICK_W-1:0];
    assign in_item_next.err    = tick_in > MAX_TICK;
    assign in_item_next.scaled = tick_in[TICK_W-1:DAY_SHIFT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            in_item_reg <= in_item_next;
        end
    end

    // Day number: the remaining odd factor of the ticks per day is divided
    // out one quotient bit per stage.
    logic      div_valid;
    day_item_t div_item;

    ttcd_divider u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (in_valid_reg),
        .in_item   (in_item_reg),
        .out_valid (div_valid),
        .out_item  (div_item)
    );

    // Calendar split into periods, then month and day from the tables.
    logic  cal_valid;
    date_t cal_date;

    ttcd_calendar u_calendar (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (div_valid),
        .in_item   (div_item),
        .out_valid (cal_valid),
        .out_date  (cal_date)
    );

    // Skid register. While it is empty the result register drives the port;
    // a result not taken moves into it as the pipeline steps on. While it is
    // full it holds the oldest result and the pipeline waits.
    date_t skid_date_reg;
    date_t m_date;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (m_tready)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (cal_valid && !m_tready)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!skid_valid_reg)
        begin
            skid_date_reg <= cal_date;
        end
    end

    assign m_date   = skid_valid_reg ? skid_date_reg : cal_date;
    assign m_tvalid = skid_valid_reg || cal_valid;
    assign m_tdata  = {m_date.leap, m_date.day, m_date.month, m_date.year};
    assign m_tuser  = m_date.err;

    // An out-of-range transfer carries an all-zero date.
    `TTCD_CHECK(a_err_zero_date, m_tvalid && m_tuser, m_tdata == '0, "range error with a date")
    // A valid date has its month, day and year in range.
    `TTCD_CHECK(a_date_range, m_tvalid && !m_tuser,
        m_date.month != '0 && m_date.month <= MONTHS && m_date.day != '0 && m_date.year != '0,
        "date field out of range")
    // A leap year is always a multiple of four.
    `TTCD_CHECK(a_leap_year, m_tvalid && m_date.leap, m_date.year[1:0] == 2'b00,
        "leap flag on a year not divisible by four")
    // Draining the skid register reopens the input in the next cycle.
    `TTCD_CHECK_NEXT(a_skid_drain, skid_valid_reg && m_tready, s_tready,
        "input still stalled after the skid register drained")

endmodule

/* sim/tb_ticks_to_civil_date_unit.sv */
// Self-checking testbench for the tick count to civil date converter.
`timescale 1ns / 1ps

module tb_ticks_to_civil_date_unit;

    import ttcd_pkg::*;

    localparam longint unsigned TICKS_PER_DAY = 64'd864000000000;
    localparam int unsigned     DAYS_400Y     = 146097;
    localparam int unsigned     DAYS_100Y     = 36524;
    localparam int unsigned     DAYS_4Y       = 1461;
    localparam int unsigned     DAYS_1Y       = 365;
    // Day number of 31 December 9999, the last day the calendar holds.
    localparam int unsigned     LAST_DAY      = 3652058;
    localparam int unsigned     LAST_YEAR     = 9999;
    localparam int unsigned     STALL_LIMIT   = 2000;
    localparam int unsigned     TAIL_CYCLES   = 80;
    localparam int unsigned     REPORT_LIMIT  = 10;

    // One converted date, laid out as the result transfer carries it.
    typedef struct packed {
        logic   out_of_range;
        logic   leap;
        dom_t   dom;
        month_t month;
        year_t  year;
    } civil_date_t;

    typedef struct packed {
        tick_t       ticks;
        civil_date_t date;
    } pending_date_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic        m_tuser;

    // Days before the first of each month; index 12 is the length of the year.
    int unsigned month_start_common [13] =
        '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334, 365};
    int unsigned month_start_leap [13] =
        '{0, 31, 60, 91, 121, 152, 182, 213, 244, 274, 305, 335, 366};

    pending_date_t pending_dates [$];

    logic        idle_enabled = 1'b1;
    int unsigned ready_stall_left = 0;
    int unsigned quiet_cycles = 0;
    int unsigned sent_count = 0;
    int unsigned date_count = 0;
    int unsigned range_error_count = 0;
    int unsigned leap_date_count = 0;
    int unsigned mismatch_count = 0;

    ticks_to_civil_date_unit i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #6 clk = ~clk;

    // Predicts the civil date for a tick count. The day number is split into
    // 400-year, 100-year, 4-year and 1-year periods; the 100-year and 1-year
    // counts saturate at three so that the final day of a long period lands on
    // 31 December rather than spilling into a fifth period.
    function automatic civil_date_t civil_date_of(input tick_t ticks);
        civil_date_t date;
        int unsigned days;
        int unsigned q400;
        int unsigned q100;
        int unsigned q4;
        int unsigned q1;
        int unsigned mon;
        int unsigned first_of_month;
        logic        leap;
        date = '0;
        if (ticks > MAX_TICK)
        begin
            date.out_of_range = 1'b1;
            return date;
        end
        days = 32'(64'(ticks) / TICKS_PER_DAY);
        q400 = days / DAYS_400Y;
        days -= q400 * DAYS_400Y;
        q100 = days / DAYS_100Y;
        if (q100 == 4)
        begin
            q100 = 3;
        end
        days -= q100 * DAYS_100Y;
        q4 = days / DAYS_4Y;
        days -= q4 * DAYS_4Y;
        q1 = days / DAYS_1Y;
        if (q1 == 4)
        begin
            q1 = 3;
        end
        days -= q1 * DAYS_1Y;
        // The fourth year of a 4-year period is a leap year, except in the last
        // 4-year period of a century, unless that century closes a 400-year cycle.
        leap = (q1 == 3) && (q4 != 24 || q100 == 3);
        // Every month has at least 28 days, so day / 32 is never past the true
        // month and at most one step forward is needed.
        mon = (days >> 5) + 1;
        if (mon > 12)
        begin
            mon = 12;
        end
        if (mon < 12 && days >= (leap ? month_start_leap[mon] : month_start_common[mon]))
        begin
            mon++;
        end
        first_of_month = leap ? month_start_leap[mon - 1] : month_start_common[mon - 1];
        date.year  = year_t'(q400 * 400 + q100 * 100 + q4 * 4 + q1 + 1);
        date.month = month_t'(mon);
        date.dom   = dom_t'(days - first_of_month + 1);
        date.leap  = leap;
        return date;
    endfunction

    function automatic tick_t random_tick_in_day();
        tick_t offset;
        case ($urandom_range(0, 3))
            0: offset = '0;
            1: offset = tick_t'(TICKS_PER_DAY - 1);
            default: offset = tick_t'({$urandom(), $urandom()} % TICKS_PER_DAY);
        endcase
        return offset;
    endfunction

    function automatic tick_t tick_of_day(input int unsigned day_number);
        return tick_t'(64'(day_number) * TICKS_PER_DAY) + random_tick_in_day();
    endfunction

    // Sends one tick count. An optional burst of idle cycles comes first; tvalid
    // is left high after the transfer so back-to-back items need no extra edge.
    task automatic send_tick(input tick_t ticks);
        int unsigned gap;
        gap = 0;
        if (idle_enabled && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 10);
        end
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, ticks};
        do
        begin
            @(posedge clk);
        end
        while (!s_tready);
        pending_dates.push_back('{ticks: ticks, date: civil_date_of(ticks)});
        sent_count++;
    endtask

    task automatic wait_until_drained();
        while (pending_dates.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // Calendar extremes and the period-clamping corners, one transfer each.
    task automatic test_directed_corners();
        send_tick('0);
        send_tick(tick_t'(TICKS_PER_DAY - 1));
        send_tick(tick_t'(TICKS_PER_DAY));
        send_tick(tick_t'(64'd30 * TICKS_PER_DAY));   // 31 January of year 1
        send_tick(tick_t'(64'd31 * TICKS_PER_DAY));   // 1 February
        send_tick(tick_t'(64'd58 * TICKS_PER_DAY));   // 28 February, common year
        send_tick(tick_t'(64'd59 * TICKS_PER_DAY));   // 1 March, common year
        send_tick(tick_t'(64'd364 * TICKS_PER_DAY));  // 31 December of year 1
        send_tick(tick_t'(64'd1154 * TICKS_PER_DAY)); // 29 February of year 4
        send_tick(tick_t'(64'd1155 * TICKS_PER_DAY)); // 1 March of year 4
        // Last day of a 4-year cycle: the 1-year count reaches four and is clamped.
        send_tick(tick_t'(64'd1460 * TICKS_PER_DAY + TICKS_PER_DAY - 1));
        send_tick(tick_t'(64'd1461 * TICKS_PER_DAY));
        // Year 100 is a century year and not a leap year.
        send_tick(tick_t'(64'd36523 * TICKS_PER_DAY));
        send_tick(tick_t'(64'd36524 * TICKS_PER_DAY));
        // Last day of a 400-year cycle: the 100-year count reaches four.
        send_tick(tick_t'(64'(DAYS_400Y - 1) * TICKS_PER_DAY));
        send_tick(tick_t'(64'(DAYS_400Y) * TICKS_PER_DAY));
        send_tick(tick_t'(64'(LAST_DAY - 364) * TICKS_PER_DAY));
        send_tick(MAX_TICK - tick_t'(TICKS_PER_DAY - 1));
        send_tick(MAX_TICK);
        // Past the end of the calendar the range error is raised.
        send_tick(MAX_TICK + 1);
        send_tick(tick_t'(64'h2000_0000_0000_0000));
        send_tick('1);
    endtask

    // Uniform day numbers across the whole calendar, with a tail beyond its end.
    task automatic test_random_dates(input int unsigned count);
        repeat (count)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                send_tick(MAX_TICK + tick_t'($urandom_range(1, 1 << 20)));
            end
            else
            begin
                send_tick(tick_of_day($urandom_range(0, LAST_DAY)));
            end
        end
    endtask

    // Days next to month and year boundaries, with century and 400-year years
    // drawn often so that every branch of the leap-year rule is exercised.
    task automatic test_month_boundaries(input int unsigned count);
        int unsigned year;
        int unsigned prior;
        int unsigned mon;
        int          day_number;
        logic        leap;
        repeat (count)
        begin
            case ($urandom_range(0, 3))
                0: year = 100 * $urandom_range(1, 99);
                1: year = 100 * $urandom_range(1, 99) + $urandom_range(0, 4);
                default: year = $urandom_range(1, LAST_YEAR);
            endcase
            if (year > LAST_YEAR)
            begin
                year = LAST_YEAR;
            end
            prior = year - 1;
            leap  = (year % 4 == 0) && ((year % 100 != 0) || (year % 400 == 0));
            mon   = $urandom_range(0, 12);
            day_number = prior * 365 + prior / 4 - prior / 100 + prior / 400
                       + (leap ? month_start_leap[mon] : month_start_common[mon]);
            case ($urandom_range(0, 3))
                0: day_number -= 1;
                1: day_number += 0;
                2: day_number += 27;
                default: day_number += 28;
            endcase
            if (day_number < 0)
            begin
                day_number = 0;
            end
            if (day_number > int'(LAST_DAY))
            begin
                day_number = LAST_DAY;
            end
            send_tick(tick_of_day(day_number));
        end
    endtask

    // Raw counts over the whole 62-bit field, so every tick-count bit toggles.
    task automatic test_raw_counts(input int unsigned count);
        repeat (count)
        begin
            send_tick(tick_t'({$urandom(), $urandom()}));
        end
    endtask

    // Short bursts, each followed by a pause until the pipeline has emptied.
    task automatic test_pause_until_drained();
        repeat (4)
        begin
            test_random_dates($urandom_range(3, 12));
            s_tvalid <= 1'b0;
            wait_until_drained();
        end
    endtask

    // Closing stretch at full rate on both sides.
    task automatic test_full_rate(input int unsigned count);
        idle_enabled = 1'b0;
        repeat (count)
        begin
            case ($urandom_range(0, 2))
                0: test_random_dates(1);
                1: test_month_boundaries(1);
                default: test_raw_counts(1);
            endcase
        end
    endtask

    // Result side: random stall bursts on tready while idling is enabled.
    always @(posedge clk)
    begin
        if (!rst_n || !idle_enabled)
        begin
            m_tready <= rst_n;
            ready_stall_left <= 0;
        end
        else if (ready_stall_left != 0)
        begin
            m_tready <= 1'b0;
            ready_stall_left <= ready_stall_left - 1;
        end
        else if ($urandom_range(0, 7) == 0)
        begin
            m_tready <= 1'b0;
            ready_stall_left <= $urandom_range(0, 9);
        end
        else
        begin
            m_tready <= 1'b1;
        end
    end

    // Compares each result transfer with the oldest outstanding prediction.
    always @(posedge clk)
    begin
        pending_date_t want;
        civil_date_t   got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.year         = m_tdata[13:0];
            got.month        = m_tdata[17:14];
            got.dom          = m_tdata[22:18];
            got.leap         = m_tdata[23];
            got.out_of_range = m_tuser;
            date_count++;
            if (got.out_of_range)
            begin
                range_error_count++;
            end
            if (got.leap)
            begin
                leap_date_count++;
            end
            if (pending_dates.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                begin
                    $display("Unexpected result: year %0d month %0d day %0d leap %0b err %0b",
                             got.year, got.month, got.dom, got.leap, got.out_of_range);
                end
            end
            else
            begin
                want = pending_dates.pop_front();
                if (got.year != want.date.year || got.month != want.date.month ||
                    got.dom != want.date.dom || got.leap != want.date.leap ||
                    got.out_of_range != want.date.out_of_range)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                    begin
                        $display("Mismatch for tick %0d: expected %0d-%0d-%0d leap %0b err %0b,",
                                 want.ticks, want.date.year, want.date.month, want.date.dom,
                                 want.date.leap, want.date.out_of_range);
                        $display("    got %0d-%0d-%0d leap %0b err %0b",
                                 got.year, got.month, got.dom, got.leap, got.out_of_range);
                    end
                end
            end
        end
    end

    // Ends the run if no transfer happens on either side for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            begin
                quiet_cycles <= 0;
            end
            else if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("Timeout: no transfer for %0d cycles, %0d results outstanding",
                         STALL_LIMIT, pending_dates.size());
                $display("FAILURE");
                $finish;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_corners();
        test_random_dates(500);
        test_month_boundaries(400);
        test_pause_until_drained();
        test_raw_counts(300);
        test_full_rate(300);

        s_tvalid <= 1'b0;
        wait_until_drained();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Converted %0d tick counts (%0d results checked), corners, month edges,",
                 sent_count, date_count);
        $display("    raw 62-bit counts; %0d leap-year dates, %0d range errors, %0d mismatches",
                 leap_date_count, range_error_count, mismatch_count);
        if (mismatch_count == 0 && pending_dates.size() == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
